// File: rtl/core/mmm_pkg.sv
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared constants and types for the matrix product entry unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mmm_pkg;

    localparam int DIM    = 32;
    localparam int IDX_W  = $clog2(DIM);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int KIND_W = 2;
    localparam int SIZE_W = 6;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 42;

    localparam logic [KIND_W-1:0] KIND_WR_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/mmm_mac.sv
// ----------------------------------------------------------------------------
// mmm_mac
// Shared multiply-accumulate unit: registered product, then full-precision sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mmm_mac
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mmm_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [mmm_pkg::ELEM_W-1:0]  a,
    input  wire logic signed [mmm_pkg::ELEM_W-1:0]  b,
    output logic signed [mmm_pkg::ACC_W-1:0]        acc,
    output logic                                    busy
);
    import mmm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.valid && !ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_v_reg;

endmodule

`default_nettype wire

// File: rtl/core/matrix_multiply_mac.sv
// ----------------------------------------------------------------------------
// matrix_multiply_mac
// Stores two square Q1.15 matrices and answers queries for one entry of A*B.
// ----------------------------------------------------------------------------
// A write item (kind 0 or 1) stores one element of A or B.
// A query item (kind 2) returns C[row][col] summed over the size in use, n
// being matrix_size capped at 32; a single multiply-accumulate consumes one
// term per cycle from the two element RAMs.
// The input side stalls while a query is in progress. Elements read by a query
// must have been written first. matrix_size may be written only while idle.
`default_nettype none

module matrix_multiply_mac
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [mmm_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [mmm_pkg::KIND_W-1:0]          kind,
    input  wire logic [mmm_pkg::IDX_W-1:0]           row,
    input  wire logic [mmm_pkg::IDX_W-1:0]           col,
    input  wire logic signed [mmm_pkg::ELEM_W-1:0]   value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [mmm_pkg::IDX_W-1:0]                out_row,
    output logic [mmm_pkg::IDX_W-1:0]                out_col,
    output logic signed [mmm_pkg::ACC_W-1:0]         product_value
);
    import mmm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam logic [CNT_W-1:0] DIM_CNT = CNT_W'(DIM);

    logic signed [ELEM_W-1:0] mem_a [DIM*DIM];
    logic signed [ELEM_W-1:0] mem_b [DIM*DIM];

    logic [1:0]               state_reg, state_next;
    logic [SIZE_W-1:0]        size_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [IDX_W-1:0]         q_row_reg, q_col_reg;
    logic                     issue_v_reg;
    logic signed [ELEM_W-1:0] rd_a_reg, rd_b_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [ACC_W-1:0]  out_val_reg;

    logic                     in_fire;
    logic                     query_fire;
    logic                     issue;
    logic                     load_out;
    logic [CNT_W-1:0]         n_sat;
    mac_ctrl_t                mac_ctrl;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     mac_busy;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign query_fire = in_fire && (kind == KIND_QUERY);
    assign issue      = (state_reg == ST_RUN) && (k_reg != n_reg);
    assign load_out   = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign n_sat      = (size_reg > SIZE_W'(DIM)) ? DIM_CNT : CNT_W'(size_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!issue_v_reg && !mac_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_W'(DIM);
            k_reg         <= '0;
            issue_v_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_v_reg <= issue;
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (query_fire)
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // element RAMs: one write port at item accept, one registered read per query step
    always_ff @(posedge clk)
    begin
        if (in_fire && (kind == KIND_WR_A))
        begin
            mem_a[{row, col}] <= value;
        end
        if (in_fire && (kind == KIND_WR_B))
        begin
            mem_b[{row, col}] <= value;
        end
        if (issue)
        begin
            rd_a_reg <= mem_a[{q_row_reg, k_reg[IDX_W-1:0]}];
            rd_b_reg <= mem_b[{k_reg[IDX_W-1:0], q_col_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            q_row_reg <= row;
            q_col_reg <= col;
            n_reg     <= n_sat;
        end
        if (load_out)
        begin
            out_row_reg <= q_row_reg;
            out_col_reg <= q_col_reg;
            out_val_reg <= mac_acc;
        end
    end

    assign mac_ctrl.clear = query_fire;
    assign mac_ctrl.valid = issue_v_reg;

    mmm_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (rd_a_reg),
        .b     (rd_b_reg),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_val_reg;

`ifndef SYNTHESIS
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> (state_reg == ST_RUN))
        else $error("query accepted but sequencer did not start");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg <= n_reg))
        else $error("term counter ran past size in use");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!issue_v_reg && !mac_busy))
        else $error("MAC pipeline not empty while idle");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result presented outside finish step");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_multiply_mac: loads A and B element by
// element, queries entries of A*B under many matrix sizes and compares each
// answer with a product computed alongside the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import mmm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 40;
    localparam int TOTAL_ITEMS = 1400;

    class product_scoreboard;
        typedef struct {
            logic [IDX_W-1:0] r;
            logic [IDX_W-1:0] c;
            logic [ACC_W-1:0] v;
        } product_t;

        logic [ELEM_W-1:0] a_mem [DIM*DIM];
        logic [ELEM_W-1:0] b_mem [DIM*DIM];
        int unsigned       size_reg;
        product_t          pending_products [$];
        int                errors;
        int                answered;

        function new();
            size_reg = 32;
            errors   = 0;
            answered = 0;
            foreach (a_mem[i]) a_mem[i] = '0;
            foreach (b_mem[i]) b_mem[i] = '0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] sz);
            size_reg = 32'(sz);
        endfunction

        function int pending();
            return pending_products.size();
        endfunction

        // sum over the size in use, capped at DIM; exact in 42 bits
        function logic [ACC_W-1:0] predict_entry(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
            longint acc;
            int     n;
            acc = 0;
            n = (size_reg > DIM) ? DIM : size_reg;
            for (int k = 0; k < n; k++)
                acc += longint'($signed(a_mem[r*DIM + k])) * longint'($signed(b_mem[k*DIM + c]));
            return acc[ACC_W-1:0];
        endfunction

        function void note_item(logic [KIND_W-1:0] k, logic [IDX_W-1:0] r,
                                logic [IDX_W-1:0] c, logic [ELEM_W-1:0] v);
            product_t p;
            if (k == KIND_WR_A)
                a_mem[r*DIM + c] = v;
            else if (k == KIND_WR_B)
                b_mem[r*DIM + c] = v;
            else if (k == KIND_QUERY) begin
                p.r = r;
                p.c = c;
                p.v = predict_entry(r, c);
                pending_products.push_back(p);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task check_result(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c, logic [ACC_W-1:0] v);
            product_t p;
            if (pending_products.size() == 0) begin
                report_mismatch($sformatf("result (%0d,%0d) with nothing pending", r, c));
                return;
            end
            p = pending_products.pop_front();
            answered++;
            if (r !== p.r)
                report_mismatch($sformatf("out_row %0d, predicted %0d", r, p.r));
            if (c !== p.c)
                report_mismatch($sformatf("out_col %0d, predicted %0d", c, p.c));
            if (v !== p.v)
                report_mismatch($sformatf("product (%0d,%0d) = %0d, predicted %0d",
                                          p.r, p.c, $signed(v), $signed(p.v)));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [SIZE_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [KIND_W-1:0]        kind = '0;
    logic [IDX_W-1:0]         row = '0;
    logic [IDX_W-1:0]         col = '0;
    logic signed [ELEM_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [ACC_W-1:0]  product_value;

    product_scoreboard sb;
    bit          a_done [DIM*DIM];
    bit          b_done [DIM*DIM];
    int unsigned cur_size = 32;
    bit          gaps_on = 1'b1;
    bit          stall_on = 1'b1;
    int          stall_left = 0;
    int          items_sent = 0;
    int          writes_sent = 0;
    int          ignored_sent = 0;
    int          size_changes = 0;
    int          cycle_count = 0;

    matrix_multiply_mac dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .row           (row),
        .col           (col),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int burst_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic int sender_gap();
        if (!gaps_on || $urandom_range(0, 99) < 50)
            return 0;
        return burst_len();
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic int used_size();
        return (cur_size > DIM) ? DIM : cur_size;
    endfunction

    function automatic int total_sent();
        return items_sent + ignored_sent;
    endfunction

    // result side: check accepted results, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_row, out_col, product_value);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (stall_on && $urandom_range(0, 99) < 25)
        begin
            out_stall  <= 1'b1;
            stall_left = burst_len() - 1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic put_item(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] v);
        int gap;
        in_valid <= 1'b1;
        kind     <= k;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(k, r, c, v);
        if (k == KIND_WR_A)
            a_done[r*DIM + c] = 1'b1;
        if (k == KIND_WR_B)
            b_done[r*DIM + c] = 1'b1;
        if (k == KIND_WR_A || k == KIND_WR_B)
            writes_sent++;
        if (k == KIND_NONE)
            ignored_sent++;
        else
            items_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // never read an element that was not written: fill the gaps first
    task automatic send_query(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                              input logic [ELEM_W-1:0] v);
        int n;
        n = used_size();
        for (int k = 0; k < n; k++)
        begin
            if (!a_done[r*DIM + k])
                put_item(KIND_WR_A, r, IDX_W'(k), rand_elem());
            if (!b_done[k*DIM + c])
                put_item(KIND_WR_B, IDX_W'(k), c, rand_elem());
        end
        put_item(KIND_QUERY, r, c, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic change_size(input logic [SIZE_W-1:0] sz);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_size = 32'(sz);
        sb.set_size(sz);
        size_changes++;
    endtask

    task automatic random_item();
        int               pick;
        int               n;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        pick = $urandom_range(0, 99);
        n    = used_size();
        r    = IDX_W'($urandom_range(0, DIM-1));
        c    = IDX_W'($urandom_range(0, DIM-1));
        if (pick < 8)
            put_item(KIND_NONE, r, c, ELEM_W'($urandom));
        else if (pick < 50)
        begin
            // half the writes land inside the span that queries read
            if ($urandom_range(0, 1) && n > 0)
            begin
                if ($urandom_range(0, 1))
                    put_item(KIND_WR_A, r, IDX_W'($urandom_range(0, n-1)), rand_elem());
                else
                    put_item(KIND_WR_B, IDX_W'($urandom_range(0, n-1)), c, rand_elem());
            end
            else
                put_item($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A, r, c, rand_elem());
        end
        else
            send_query(r, c, ELEM_W'($urandom));
        if ($urandom_range(0, 199) == 0)
            drain();
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return SIZE_W'($urandom_range(1, 6));
        if (pick < 70) return SIZE_W'($urandom_range(7, 16));
        if (pick < 78) return 6'd32;
        if (pick < 86) return SIZE_W'($urandom_range(33, 63));
        if (pick < 92) return 6'd0;
        return SIZE_W'($urandom_range(17, 31));
    endfunction

    initial
    begin
        int phase_items;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size from reset: extreme rows and columns of both matrices
        for (int k = 0; k < DIM; k++)
        begin
            put_item(KIND_WR_A, 5'd31, IDX_W'(k), 16'h8000);
            put_item(KIND_WR_B, IDX_W'(k), 5'd31, 16'h8000);
        end
        put_item(KIND_QUERY, 5'd31, 5'd31, 16'h0000);
        for (int k = 0; k < DIM; k++)
        begin
            put_item(KIND_WR_A, 5'd0, IDX_W'(k), 16'h7fff);
            put_item(KIND_WR_B, IDX_W'(k), 5'd0, 16'h8000);
        end
        put_item(KIND_QUERY, 5'd0, 5'd0, 16'h7fff);
        put_item(KIND_QUERY, 5'd0, 5'd31, 16'h8000);
        put_item(KIND_QUERY, 5'd31, 5'd0, 16'hffff);

        change_size(6'd2);
        put_item(KIND_WR_A, 5'd3, 5'd0, 16'h8000);
        put_item(KIND_WR_A, 5'd3, 5'd1, 16'h8000);
        put_item(KIND_WR_B, 5'd0, 5'd3, 16'h7fff);
        put_item(KIND_WR_B, 5'd1, 5'd3, 16'hffff);
        put_item(KIND_QUERY, 5'd3, 5'd3, 16'hffff);
        put_item(KIND_NONE, 5'd31, 5'd31, 16'hffff);
        put_item(KIND_NONE, 5'd0, 5'd0, 16'h0000);
        put_item(KIND_WR_B, 5'd0, 5'd0, 16'h0000);
        put_item(KIND_QUERY, 5'd0, 5'd0, 16'h5a5a);

        // empty sum, then a size past DIM that caps at DIM, then the smallest non-empty size
        change_size(6'd0);
        put_item(KIND_QUERY, 5'd17, 5'd9, 16'h1234);
        change_size(6'd63);
        put_item(KIND_QUERY, 5'd31, 5'd31, 16'h0000);
        change_size(6'd1);
        put_item(KIND_QUERY, 5'd3, 5'd31, 16'h0000);

        while (total_sent() < TOTAL_ITEMS)
        begin
            change_size(pick_size());
            gaps_on     = ($urandom_range(0, 3) != 0);
            stall_on    = ($urandom_range(0, 3) != 0);
            phase_items = $urandom_range(80, 200);
            for (int i = 0; i < phase_items && total_sent() < TOTAL_ITEMS; i++)
                random_item();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d element writes, %0d answered queries, %0d ignored items",
                 writes_sent, sb.answered, ignored_sent);
        $display("over %0d size changes incl. sizes 0, 1, 32 and above 32; %0d mismatches",
                 size_changes, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
